### sv/tsr_pkg.sv
// tsr_pkg: shared types and constants of the track segment reservation block.
// Holds table sizes, the owner entry layout, the request item and the memory request.
// No dependencies.
package tsr_pkg;

  localparam int SEGMENTS    = 256;
  localparam int TRAIN_IDS   = 128;
  localparam int MAX_EDGES   = 5;
  localparam int LIST_FIELDS = 5;

  localparam int LIMIT = (MAX_EDGES < LIST_FIELDS) ? MAX_EDGES : LIST_FIELDS;

  localparam int SEG_W       = $clog2(SEGMENTS);
  localparam int TRAIN_W     = $clog2(TRAIN_IDS);
  localparam int SEG_CMP_W   = 13;
  localparam int TRAIN_CMP_W = 9;
  localparam int CNT_W       = 3;

  localparam logic CMD_RESERVE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic               held;
    logic [TRAIN_W-1:0] id;
  } owner_t;

  typedef struct packed {
    logic                        cmd;
    logic [6:0]                  train;
    logic [CNT_W-1:0]            segment_count;
    logic [LIST_FIELDS-1:0][7:0] segment;
  } item_t;

  typedef struct packed {
    logic             we;
    logic [SEG_W-1:0] waddr;
    owner_t           wdata;
    logic [SEG_W-1:0] raddr;
  } ram_req_t;

endpackage

### sv/track_segment_reservation.sv
// Track segment reservation: reserve or release up to five segments per item.
// Each listed segment is read (S_ISSUE), then checked or written (S_EVAL); a release makes one
// pass over the list, a reserve two (a check pass, then an update pass).
// One item at a time: the next is accepted only after this one's result is registered, and the
// result is held back while a previous result waits on out_tready.
// Reset: synchronous active-low rst_n; then a clearing pass over all 256 entries with in_tready low.
module track_segment_reservation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] train, [9:7] segment_count, [17:10] segment_0, [25:18] segment_1,
  // [33:26] segment_2, [41:34] segment_3, [49:42] segment_4, [55:50] zero
  input  logic [55:0] in_tdata,
  // [0] cmd
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] granted, [5:1] changed_mask, [7:6] zero
  output logic [7:0]  out_tdata
);
  import tsr_pkg::*;

  item_t                  item;
  ram_req_t               ram_req;
  owner_t                 ram_rd;
  logic                   granted;
  logic [LIST_FIELDS-1:0] mask;

  always_comb begin
    item.cmd           = in_tuser;
    item.train         = in_tdata[6:0];
    item.segment_count = in_tdata[9:7];
    for (int i = 0; i < LIST_FIELDS; i++) begin
      item.segment[i] = in_tdata[10 + 8*i +: 8];
    end
  end

  tsr_owner_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  tsr_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_granted (granted),
    .out_mask    (mask),
    .ram_req     (ram_req),
    .ram_rd      (ram_rd)
  );

  assign out_tdata = {2'b00, mask, granted};

endmodule

### sv/tsr_owner_ram.sv
// tsr_owner_ram: owner table, one entry per segment, one write and one read port.
// Read data is registered. Depends on tsr_pkg.
module tsr_owner_ram (
  input  logic             clk,
  input  tsr_pkg::ram_req_t req,
  output tsr_pkg::owner_t   rd_data
);
  import tsr_pkg::*;

  owner_t mem [SEGMENTS];
  owner_t rd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_r <= mem[req.raddr];
  end

  assign rd_data = rd_r;

endmodule

### sv/tsr_seq.sv
// tsr_seq: sequencer that checks and updates the owner table one listed segment at a time.
// Runs the clearing pass after reset and holds the result register. Depends on tsr_pkg.
module tsr_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tsr_pkg::item_t               in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_granted,
  output logic [tsr_pkg::LIST_FIELDS-1:0] out_mask,
  output tsr_pkg::ram_req_t            ram_req,
  input  tsr_pkg::owner_t              ram_rd
);
  import tsr_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [SEG_W-1:0]            clr_r, clr_nxt;
  logic                        cmd_r, cmd_nxt;
  logic [6:0]                  train_r, train_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [LIST_FIELDS-1:0][7:0] seg_r, seg_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  logic                        apply_r, apply_nxt;
  logic [LIST_FIELDS-1:0]      mask_r, mask_nxt;
  logic                        grant_r, grant_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_granted_r, out_granted_nxt;
  logic [LIST_FIELDS-1:0]      out_mask_r, out_mask_nxt;

  logic             in_acc;
  logic [CNT_W-1:0] count_eff;
  logic [7:0]       cur_seg;
  logic             seg_bad;
  logic             owned_other;
  logic             owned_self;
  logic             last_elem;
  logic [LIST_FIELDS-1:0] idx_bit;
  ram_req_t         req;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign count_eff = (in_item.segment_count > CNT_W'(LIMIT)) ? CNT_W'(LIMIT)
                                                             : in_item.segment_count;
  assign cur_seg     = seg_r[idx_r];
  assign seg_bad     = SEG_CMP_W'(cur_seg) >= SEG_CMP_W'(SEGMENTS);
  assign owned_self  = ram_rd.held && (ram_rd.id == TRAIN_W'(train_r));
  assign owned_other = ram_rd.held && (ram_rd.id != TRAIN_W'(train_r));
  assign last_elem   = ((idx_r + CNT_W'(1)) == count_r);
  assign idx_bit     = LIST_FIELDS'(1) << idx_r;

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    cmd_nxt         = cmd_r;
    train_nxt       = train_r;
    count_nxt       = count_r;
    seg_nxt         = seg_r;
    idx_nxt         = idx_r;
    apply_nxt       = apply_r;
    mask_nxt        = mask_r;
    grant_nxt       = grant_r;
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_mask_nxt    = out_mask_r;
    req.we          = 1'b0;
    req.waddr       = SEG_W'(cur_seg);
    req.wdata       = '0;
    req.raddr       = SEG_W'(cur_seg);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_r;
        clr_nxt   = clr_r + SEG_W'(1);
        if (clr_r == SEG_W'(SEGMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_item.cmd;
          train_nxt = in_item.train;
          count_nxt = count_eff;
          seg_nxt   = in_item.segment;
          idx_nxt   = '0;
          mask_nxt  = '0;
          apply_nxt = (in_item.cmd == CMD_RELEASE);
          priority if (TRAIN_CMP_W'(in_item.train) >= TRAIN_CMP_W'(TRAIN_IDS)) begin
            grant_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else if (count_eff == '0) begin
            grant_nxt = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        // out-of-range index: refuses a reserve, is skipped by a release
        if (seg_bad) begin
          if (cmd_r == CMD_RESERVE) begin
            grant_nxt = 1'b0;
            mask_nxt  = '0;
            state_nxt = S_FINISH;
          end else if (last_elem) begin
            grant_nxt = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_ISSUE;
        if (!apply_r) begin
          if (owned_other) begin
            grant_nxt = 1'b0;
            state_nxt = S_FINISH;
          end else if (last_elem) begin
            apply_nxt = 1'b1;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end else begin
          if (cmd_r == CMD_RESERVE) begin
            req.we        = 1'b1;
            req.wdata.held = 1'b1;
            req.wdata.id   = TRAIN_W'(train_r);
            if (!ram_rd.held) begin
              mask_nxt = mask_r | idx_bit;
            end
          end else if (owned_self) begin
            req.we   = 1'b1;
            mask_nxt = mask_r | idx_bit;
          end
          if (last_elem) begin
            grant_nxt = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = grant_r;
          out_mask_nxt    = grant_r ? mask_r : '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    train_r       <= train_nxt;
    count_r       <= count_nxt;
    seg_r         <= seg_nxt;
    idx_r         <= idx_nxt;
    apply_r       <= apply_nxt;
    mask_r        <= mask_nxt;
    grant_r       <= grant_nxt;
    out_granted_r <= out_granted_nxt;
    out_mask_r    <= out_mask_nxt;
  end

  assign ram_req     = req;
  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_mask    = out_mask_r;

`ifndef SYNTH
  a_refused_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_granted_r |-> out_mask_r == '0)
    else $error("refused result carries a nonzero mask");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    req.we |-> (state_r == S_EVAL && apply_r) || state_r == S_CLEAR)
    else $error("table written outside the update pass or clearing");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ISSUE || state_r == S_EVAL |-> idx_r < count_r)
    else $error("segment index walked past the list");
`endif

endmodule
